FILE: rtl/tpc_pkg.sv
// types, constants and helpers shared by the triangle plane clipper
package tpc_pkg;

	localparam int C_W       = 32;
	localparam int P_W       = 2 * C_W;
	localparam int H_W       = P_W - 16;
	localparam int D_W       = H_W + 4;
	localparam int DV_W      = D_W + 1;
	localparam int T_W       = 16;
	localparam int DL_W      = C_W + 1 + T_W + 1;
	localparam int DATA_W    = 10 * C_W;
	localparam int TRI_W     = 9 * C_W;
	localparam int CFG_IDX_W = 3;

	localparam int DIV_BITS_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PZ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NZ = 3'd5;

	localparam logic [C_W-1:0] RST_PX = 32'd0;
	localparam logic [C_W-1:0] RST_PY = 32'd0;
	localparam logic [C_W-1:0] RST_PZ = 32'd6554;
	localparam logic [C_W-1:0] RST_NX = 32'd0;
	localparam logic [C_W-1:0] RST_NY = 32'd0;
	localparam logic [C_W-1:0] RST_NZ = 32'd65536;

	typedef logic [C_W-1:0] crd_t;
	typedef crd_t [2:0] vtx_t;
	typedef vtx_t [2:0] tri_t;

	typedef enum logic [1:0] {
		CL_ALL,
		CL_ONE,
		CL_TWO
	} clip_t;

	typedef struct packed {
		clip_t code;
		vtx_t  p0;
		vtx_t  p1;
		vtx_t  p2;
		vtx_t  e0;
		vtx_t  e1;
		vtx_t  s1;
		crd_t  shade;
	} item_t;

	function automatic logic signed [D_W-1:0] sh16(input logic signed [P_W-1:0] p);
		logic signed [H_W-1:0] h;
		h = p[P_W-1:16];
		return D_W'(h);
	endfunction

endpackage

FILE: rtl/triangle_plane_clipper.sv
// triangle clipper against one configured plane, top level
//
// usage:
//   slave stream takes one triangle per transaction: tdata holds nine Q16.16
//   coordinates a.x .. c.z and the shade word. the master stream gives zero,
//   one or two triangles per input, tlast marks the last one of an input.
//   the config channel writes the plane point and normal by index; it is
//   always ready and must only be used while no triangle is in flight.
// timing:
//   a triangle passes stages 1 to 4, the divider stages, stages 6, 7 and
//   the output register. a new triangle can enter every cycle unless the
//   output stalls: it sends one triangle per cycle while m_tready is high,
//   and an input that splits in two holds it until both are sent. the crossing
//   parameter comes from a pipelined divider, DIV_BITS quotient bits per stage.
// reset:
//   all pipeline valids clear and the plane goes back to z = 0.1, normal +z.
// stall:
//   each stage holds while the next one is full, bubbles close up, and the
//   input stays ready until the pipeline is full behind a stalled output.
module triangle_plane_clipper #(
	parameter int DIV_BITS = tpc_pkg::DIV_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, shade
	input  logic [tpc_pkg::DATA_W-1:0]      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, shade
	output logic [tpc_pkg::DATA_W-1:0]      m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpc_pkg::C_W-1:0]         cfg_data
);
	import tpc_pkg::*;

	localparam int NDIV = T_W / DIV_BITS;

	// plane registers
	crd_t pnt_q [3];
	crd_t nrm_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnt_q[0] <= RST_PX;
			pnt_q[1] <= RST_PY;
			pnt_q[2] <= RST_PZ;
			nrm_q[0] <= RST_NX;
			nrm_q[1] <= RST_NY;
			nrm_q[2] <= RST_NZ;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PX: pnt_q[0] <= cfg_data;
				REG_PY: pnt_q[1] <= cfg_data;
				REG_PZ: pnt_q[2] <= cfg_data;
				REG_NX: nrm_q[0] <= cfg_data;
				REG_NY: nrm_q[1] <= cfg_data;
				REG_NZ: nrm_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s6, v_s7, ov_q;
	logic dv_v_s5 [NDIV];
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s6, adv_s7, adv_o;
	logic adv_d [NDIV];
	logic ph_q, two_q;

	assign m_tvalid = ov_q;
	assign m_tlast  = !two_q || ph_q;

	always_comb begin
		adv_o  = !ov_q || (m_tready && m_tlast);
		adv_s7 = !v_s7 || adv_o;
		adv_s6 = !v_s6 || adv_s7;
		adv_d[NDIV-1] = !dv_v_s5[NDIV-1] || adv_s6;
		for (int k = NDIV - 2; k >= 0; k--) begin
			adv_d[k] = !dv_v_s5[k] || adv_d[k+1];
		end
		adv_s4 = !v_s4 || adv_d[0];
		adv_s3 = !v_s3 || adv_s4;
		adv_s2 = !v_s2 || adv_s3;
		adv_s1 = !v_s1 || adv_s2;
	end

	assign s_tready = adv_s1;

	// stage 1: products
	tri_t tri_in;
	assign tri_in = s_tdata[TRI_W-1:0];

	tri_t tri_s1;
	crd_t shade_s1;
	logic signed [P_W-1:0] pv_s1 [3][3];
	logic signed [P_W-1:0] pp_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv_s1) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tri_s1   <= tri_in;
			shade_s1 <= s_tdata[DATA_W-1:TRI_W];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pv_s1[i][j] <= $signed(nrm_q[j]) * $signed(tri_in[i][j]);
				end
			end
			for (int j = 0; j < 3; j++) begin
				pp_s1[j] <= $signed(nrm_q[j]) * $signed(pnt_q[j]);
			end
		end
	end

	// stage 2: dot products
	tri_t tri_s2;
	crd_t shade_s2;
	logic signed [D_W-1:0] nv_s2 [3];
	logic signed [D_W-1:0] np_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			tri_s2   <= tri_s1;
			shade_s2 <= shade_s1;
			for (int i = 0; i < 3; i++) begin
				nv_s2[i] <= sh16(pv_s1[i][0]) + sh16(pv_s1[i][1]) + sh16(pv_s1[i][2]);
			end
			np_s2 <= sh16(pp_s1[0]) + sh16(pp_s1[1]) + sh16(pp_s1[2]);
		end
	end

	// stage 3: distances
	tri_t tri_s3;
	crd_t shade_s3;
	logic signed [D_W-1:0] d_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv_s3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			tri_s3   <= tri_s2;
			shade_s3 <= shade_s2;
			for (int i = 0; i < 3; i++) begin
				d_s3[i] <= nv_s2[i] - np_s2;
			end
		end
	end

	// stage 4: classify and set up the two crossings
	logic [2:0] ins;
	item_t item_c;
	logic signed [D_W-1:0] ds0, de0, ds1, de1;

	always_comb begin
		ins = {!d_s3[0][D_W-1], !d_s3[1][D_W-1], !d_s3[2][D_W-1]};
		item_c       = '0;
		item_c.shade = shade_s3;
		item_c.p0    = tri_s3[0];
		item_c.p1    = tri_s3[1];
		item_c.p2    = tri_s3[2];
		item_c.code  = CL_ALL;
		ds0 = d_s3[0];
		de0 = d_s3[1];
		ds1 = d_s3[0];
		de1 = d_s3[2];
		case (ins)
			3'b100: begin
				item_c.code = CL_ONE;
				item_c.p0 = tri_s3[0]; item_c.s1 = tri_s3[0];
				item_c.e0 = tri_s3[1]; item_c.e1 = tri_s3[2];
				ds0 = d_s3[0]; de0 = d_s3[1]; ds1 = d_s3[0]; de1 = d_s3[2];
			end
			3'b010: begin
				item_c.code = CL_ONE;
				item_c.p0 = tri_s3[1]; item_c.s1 = tri_s3[1];
				item_c.e0 = tri_s3[0]; item_c.e1 = tri_s3[2];
				ds0 = d_s3[1]; de0 = d_s3[0]; ds1 = d_s3[1]; de1 = d_s3[2];
			end
			3'b001: begin
				item_c.code = CL_ONE;
				item_c.p0 = tri_s3[2]; item_c.s1 = tri_s3[2];
				item_c.e0 = tri_s3[0]; item_c.e1 = tri_s3[1];
				ds0 = d_s3[2]; de0 = d_s3[0]; ds1 = d_s3[2]; de1 = d_s3[1];
			end
			3'b110: begin
				item_c.code = CL_TWO;
				item_c.p0 = tri_s3[0]; item_c.p1 = tri_s3[1]; item_c.s1 = tri_s3[1];
				item_c.e0 = tri_s3[2]; item_c.e1 = tri_s3[2];
				ds0 = d_s3[0]; de0 = d_s3[2]; ds1 = d_s3[1]; de1 = d_s3[2];
			end
			3'b101: begin
				item_c.code = CL_TWO;
				item_c.p0 = tri_s3[0]; item_c.p1 = tri_s3[2]; item_c.s1 = tri_s3[2];
				item_c.e0 = tri_s3[1]; item_c.e1 = tri_s3[1];
				ds0 = d_s3[0]; de0 = d_s3[1]; ds1 = d_s3[2]; de1 = d_s3[1];
			end
			3'b011: begin
				item_c.code = CL_TWO;
				item_c.p0 = tri_s3[1]; item_c.p1 = tri_s3[2]; item_c.s1 = tri_s3[2];
				item_c.e0 = tri_s3[0]; item_c.e1 = tri_s3[0];
				ds0 = d_s3[1]; de0 = d_s3[0]; ds1 = d_s3[2]; de1 = d_s3[0];
			end
			default: item_c.code = CL_ALL;
		endcase
	end

	item_t item_s4;
	logic [DV_W-1:0] den0_s4, den1_s4, rem0_s4, rem1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv_s4) v_s4 <= v_s3 && (ins != 3'b000);
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			item_s4 <= item_c;
			den0_s4 <= DV_W'(ds0) - DV_W'(de0);
			den1_s4 <= DV_W'(ds1) - DV_W'(de1);
			rem0_s4 <= DV_W'(ds0);
			rem1_s4 <= DV_W'(ds1);
		end
	end

	// divider stages
	item_t           item_s5 [NDIV];
	logic [DV_W-1:0] den0_s5 [NDIV];
	logic [DV_W-1:0] den1_s5 [NDIV];
	logic [DV_W-1:0] rem0_s5 [NDIV];
	logic [DV_W-1:0] rem1_s5 [NDIV];
	logic [T_W-1:0]  t0_s5   [NDIV];
	logic [T_W-1:0]  t1_s5   [NDIV];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic            v_in;
		item_t           item_in;
		logic [DV_W-1:0] den0_in, den1_in, rem0_in, rem1_in, rem0_nx, rem1_nx;
		logic [T_W-1:0]  t0_in, t1_in, t0_nx, t1_nx;

		if (k == 0) begin : g_first
			assign v_in    = v_s4;
			assign item_in = item_s4;
			assign den0_in = den0_s4;
			assign den1_in = den1_s4;
			assign rem0_in = rem0_s4;
			assign rem1_in = rem1_s4;
			assign t0_in   = '0;
			assign t1_in   = '0;
		end else begin : g_next
			assign v_in    = dv_v_s5[k-1];
			assign item_in = item_s5[k-1];
			assign den0_in = den0_s5[k-1];
			assign den1_in = den1_s5[k-1];
			assign rem0_in = rem0_s5[k-1];
			assign rem1_in = rem1_s5[k-1];
			assign t0_in   = t0_s5[k-1];
			assign t1_in   = t1_s5[k-1];
		end

		tpc_div_step #(.STEPS(DIV_BITS)) u_step0 (
			.rem(rem0_in), .den(den0_in), .quo(t0_in), .rem_nx(rem0_nx), .quo_nx(t0_nx)
		);
		tpc_div_step #(.STEPS(DIV_BITS)) u_step1 (
			.rem(rem1_in), .den(den1_in), .quo(t1_in), .rem_nx(rem1_nx), .quo_nx(t1_nx)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s5[k] <= 1'b0;
			else if (adv_d[k]) dv_v_s5[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv_d[k]) begin
				item_s5[k] <= item_in;
				den0_s5[k] <= den0_in;
				den1_s5[k] <= den1_in;
				rem0_s5[k] <= rem0_nx;
				rem1_s5[k] <= rem1_nx;
				t0_s5[k]   <= t0_nx;
				t1_s5[k]   <= t1_nx;
			end
		end
	end

	// stage 6: edge deltas times t
	item_t item_s6;
	logic signed [DL_W-1:0] dl0_s6 [3];
	logic signed [DL_W-1:0] dl1_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv_s6) v_s6 <= dv_v_s5[NDIV-1];
	end

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			item_s6 <= item_s5[NDIV-1];
			for (int j = 0; j < 3; j++) begin
				dl0_s6[j] <= ($signed({item_s5[NDIV-1].e0[j][C_W-1], item_s5[NDIV-1].e0[j]})
					- $signed({item_s5[NDIV-1].p0[j][C_W-1], item_s5[NDIV-1].p0[j]}))
					* $signed({1'b0, t0_s5[NDIV-1]});
				dl1_s6[j] <= ($signed({item_s5[NDIV-1].e1[j][C_W-1], item_s5[NDIV-1].e1[j]})
					- $signed({item_s5[NDIV-1].s1[j][C_W-1], item_s5[NDIV-1].s1[j]}))
					* $signed({1'b0, t1_s5[NDIV-1]});
			end
		end
	end

	// stage 7: crossing points and output triangles
	vtx_t x0, x1;
	tri_t ta_c, tb_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			x0[j] = item_s6.p0[j] + crd_t'(dl0_s6[j][C_W+T_W-1:T_W]);
			x1[j] = item_s6.s1[j] + crd_t'(dl1_s6[j][C_W+T_W-1:T_W]);
		end
		ta_c = {item_s6.p2, item_s6.p1, item_s6.p0};
		tb_c = {x1, x0, item_s6.p1};
		case (item_s6.code)
			CL_ALL:  ta_c = {item_s6.p2, item_s6.p1, item_s6.p0};
			CL_ONE:  ta_c = {x1, x0, item_s6.p0};
			CL_TWO:  ta_c = {x0, item_s6.p1, item_s6.p0};
			default: ta_c = {item_s6.p2, item_s6.p1, item_s6.p0};
		endcase
	end

	tri_t ta_s7, tb_s7;
	crd_t shade_s7;
	logic two_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv_s7) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			ta_s7    <= ta_c;
			tb_s7    <= tb_c;
			shade_s7 <= item_s6.shade;
			two_s7   <= (item_s6.code == CL_TWO);
		end
	end

	// output register, sends one or two triangles
	tri_t ta_q, tb_q;
	crd_t shade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			ph_q  <= 1'b0;
			two_q <= 1'b0;
		end else if (adv_o) begin
			ov_q  <= v_s7;
			ph_q  <= 1'b0;
			two_q <= two_s7;
		end else if (m_tready) begin
			ph_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			ta_q    <= ta_s7;
			tb_q    <= tb_s7;
			shade_q <= shade_s7;
		end
	end

	assign m_tdata = {shade_q, (ph_q ? tb_q : ta_q)};

endmodule

FILE: rtl/tpc_div_step.sv
// STEPS restoring division steps for the crossing parameter
module tpc_div_step #(
	parameter int STEPS = 2
) (
	input  logic [tpc_pkg::DV_W-1:0] rem,
	input  logic [tpc_pkg::DV_W-1:0] den,
	input  logic [tpc_pkg::T_W-1:0]  quo,
	output logic [tpc_pkg::DV_W-1:0] rem_nx,
	output logic [tpc_pkg::T_W-1:0]  quo_nx
);
	import tpc_pkg::*;

	always_comb begin
		logic [DV_W:0]   r;
		logic [DV_W-1:0] rr;
		logic [T_W-1:0]  tt;
		rr = rem;
		tt = quo;
		for (int s = 0; s < STEPS; s++) begin
			r = {rr, 1'b0};
			if (r >= {1'b0, den}) begin
				r  = r - {1'b0, den};
				tt = {tt[T_W-2:0], 1'b1};
			end else begin
				tt = {tt[T_W-2:0], 1'b0};
			end
			rr = r[DV_W-1:0];
		end
		rem_nx = rr;
		quo_nx = tt;
	end

endmodule

FILE: test/triangle_plane_clipper_tb.sv
// self-checking testbench for the triangle plane clipper: random and directed triangles
`timescale 1ns / 100ps

module triangle_plane_clipper_tb;
	import tpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int SETTLE = 40;

	typedef struct {
		logic [DATA_W-1:0] tdata;
		logic              tlast;
	} tri_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [C_W-1:0]        cfg_data;

	logic [DATA_W-1:0] pending_tris[$];
	tri_out_t          clipped_tris[$];
	logic signed [79:0] plane[6];
	int  fails;
	int  n_in;
	int  in_gap;
	int  out_stall;
	int  hold_left;
	bit  hold_done;
	bit  burst;

	triangle_plane_clipper dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [79:0] floor16(input logic signed [79:0] x);
		return x >>> 16;
	endfunction

	function automatic logic signed [79:0] sx(input logic [C_W-1:0] v);
		return 80'(signed'(v));
	endfunction

	function automatic logic signed [79:0] plane_dist(input logic signed [79:0] v[3]);
		return floor16(plane[REG_NX] * v[0]) + floor16(plane[REG_NY] * v[1])
			+ floor16(plane[REG_NZ] * v[2]) - floor16(plane[REG_NX] * plane[REG_PX])
			- floor16(plane[REG_NY] * plane[REG_PY]) - floor16(plane[REG_NZ] * plane[REG_PZ]);
	endfunction

	function automatic logic [3*C_W-1:0] crossing(input logic signed [79:0] s[3],
			input logic signed [79:0] ds, input logic signed [79:0] e[3],
			input logic signed [79:0] de);
		logic signed [79:0] t;
		logic [3*C_W-1:0] r;
		t = (ds <<< 16) / (ds - de);
		for (int k = 0; k < 3; k++)
			r[k*C_W +: C_W] = C_W'(s[k] + floor16((e[k] - s[k]) * t));
		return r;
	endfunction

	function automatic logic [3*C_W-1:0] vpack(input logic signed [79:0] v[3]);
		return {C_W'(v[2]), C_W'(v[1]), C_W'(v[0])};
	endfunction

	function automatic void add_tri(input logic [DATA_W-1:0] t);
		pending_tris.insert(pending_tris.size(), t);
	endfunction

	function automatic void add_expected(input tri_out_t r);
		clipped_tris.insert(clipped_tris.size(), r);
	endfunction

	task automatic predict_clip(input logic [DATA_W-1:0] d);
		logic signed [79:0] v[3][3];
		logic signed [79:0] ins[3][3];
		logic signed [79:0] outs[3][3];
		logic signed [79:0] vd, din[3], dout[3];
		logic [C_W-1:0] shade;
		logic [3*C_W-1:0] x0, x1;
		tri_out_t r;
		int ni, no;
		ni = 0;
		no = 0;
		shade = d[9*C_W +: C_W];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				v[i][j] = sx(d[(i*3+j)*C_W +: C_W]);
			vd = plane_dist(v[i]);
			if (vd >= 0) begin
				ins[ni] = v[i];
				din[ni] = vd;
				ni++;
			end else begin
				outs[no] = v[i];
				dout[no] = vd;
				no++;
			end
		end
		if (ni == 3) begin
			r.tdata = d;
			r.tlast = 1;
			add_expected(r);
		end else if (ni == 1) begin
			x0 = crossing(ins[0], din[0], outs[0], dout[0]);
			x1 = crossing(ins[0], din[0], outs[1], dout[1]);
			r.tdata = {shade, x1, x0, vpack(ins[0])};
			r.tlast = 1;
			add_expected(r);
		end else if (ni == 2) begin
			x0 = crossing(ins[0], din[0], outs[0], dout[0]);
			x1 = crossing(ins[1], din[1], outs[0], dout[0]);
			r.tdata = {shade, x0, vpack(ins[1]), vpack(ins[0])};
			r.tlast = 0;
			add_expected(r);
			r.tdata = {shade, x1, x0, vpack(ins[1])};
			r.tlast = 1;
			add_expected(r);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			in_gap = 0;
			n_in <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_clip(s_tdata);
				n_in <= n_in + 1;
				in_gap = burst ? 0 : $urandom_range(0, 19);
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 0;
				end else if (pending_tris.size() > 0) begin
					s_tdata <= pending_tris[0];
					pending_tris.delete(0);
					s_tvalid <= 1;
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tri_out_t x;
		if (!arst_n) begin
			m_tready <= 0;
			out_stall = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (clipped_tris.size() == 0) begin
					$display("%0t: unexpected triangle %h last %b", $time, m_tdata, m_tlast);
					fails++;
				end else begin
					x = clipped_tris[0];
					clipped_tris.delete(0);
					for (int f = 0; f < 10; f++)
						if (m_tdata[f*C_W +: C_W] !== x.tdata[f*C_W +: C_W]) begin
							$display("%0t: field %0d expected %h actual %h", $time, f,
								x.tdata[f*C_W +: C_W], m_tdata[f*C_W +: C_W]);
							fails++;
						end
					if (m_tlast !== x.tlast) begin
						$display("%0t: tlast expected %b actual %b", $time, x.tlast, m_tlast);
						fails++;
					end
				end
				out_stall = burst ? 0 : $urandom_range(0, 19);
			end
			if (!hold_done && n_in >= 500) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else if (out_stall > 0) begin
				out_stall--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [C_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_NZ)
			plane[idx] = sx(val);
		cfg_valid <= 0;
	endtask

	task automatic write_plane(input logic [C_W-1:0] px, py, pz, nx, ny, nz);
		write_reg(REG_PX, px);
		write_reg(REG_PY, py);
		write_reg(REG_PZ, pz);
		write_reg(REG_NX, nx);
		write_reg(REG_NY, ny);
		write_reg(REG_NZ, nz);
	endtask

	task automatic drain;
		do @(posedge clk); while (pending_tris.size() > 0 || s_tvalid || clipped_tris.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [C_W-1:0] rand_crd;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return C_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic logic [DATA_W-1:0] rand_tri;
		logic [DATA_W-1:0] t;
		for (int f = 0; f < 9; f++)
			t[f*C_W +: C_W] = rand_crd();
		t[9*C_W +: C_W] = $urandom;
		return t;
	endfunction

	function automatic logic [DATA_W-1:0] zt(input int az, bz, cz, input logic [C_W-1:0] sh);
		return {sh, C_W'(cz), C_W'(-65536), C_W'(65536), C_W'(bz), C_W'(65536), C_W'(0),
			C_W'(az), C_W'(0), C_W'(65536)};
	endfunction

	initial begin
		fails = 0;
		burst = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		plane[REG_PX] = sx(RST_PX);
		plane[REG_PY] = sx(RST_PY);
		plane[REG_PZ] = sx(RST_PZ);
		plane[REG_NX] = sx(RST_NX);
		plane[REG_NY] = sx(RST_NY);
		plane[REG_NZ] = sx(RST_NZ);
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// reset plane: inside is z >= 6554
		add_tri(zt(70000, 80000, 90000, 32'h0000_0000));
		add_tri(zt(-70000, -80000, 0, 32'hFFFF_FFFF));
		add_tri(zt(70000, -80000, -90000, 32'h1234_5678));
		add_tri(zt(-70000, 80000, -90000, 32'h8765_4321));
		add_tri(zt(-70000, -80000, 90000, 32'hA5A5_5A5A));
		add_tri(zt(70000, 80000, -90000, 32'h5A5A_A5A5));
		add_tri(zt(70000, -80000, 90000, 32'hDEAD_BEEF));
		add_tri(zt(-70000, 80000, 90000, 32'h0F0F_F0F0));
		add_tri(zt(6554, 6553, 6553, 32'h1));
		add_tri(zt(6553, 6554, 6554, 32'h2));
		add_tri(zt(6554, 6554, 6554, 32'h3));
		add_tri({32'hFFFF_FFFF, {9{32'h7FFF_FFFF}}});
		add_tri({32'h0, {9{32'h8000_0000}}});
		add_tri({32'hC3C3_3C3C, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000});
		add_tri(zt(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h77));
		add_tri(zt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h88));
		add_tri(zt(32'h8000_0000, 32'h7FFF_FFFF, 6554, 32'h99));
		repeat (20) add_tri(rand_tri());
		drain();

		// zero normal passes everything through
		write_plane($urandom, $urandom, $urandom, 0, 0, 0);
		repeat (100) add_tri(rand_tri());
		drain();

		// extreme plane values
		write_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		repeat (100) add_tri(rand_tri());
		drain();
		write_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		repeat (100) add_tri(rand_tri());
		drain();

		// x <= 0 half space, no random input gaps or output stalls
		burst = 1;
		write_plane(0, 0, 0, C_W'(-65536), 0, 0);
		repeat (350) add_tri(rand_tri());
		drain();
		burst = 0;

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_SPARE_6, $urandom);
			write_reg(REG_SPARE_7, $urandom);
			if (ph == 3)
				write_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				write_plane(C_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16)),
					C_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16)),
					C_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16)),
					C_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
					C_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
					C_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
			burst = (ph == 1);
			repeat (260) add_tri(rand_tri());
			drain();
		end

		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
